[sv/ssf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssf_pkg
// Shared types and constants of the shortest-seek-first request scheduler.
// ----------------------------------------------------------------------------
package ssf_pkg;

  // fixed widths of the beat fields
  localparam int unsigned TRACK_W = 16;
  localparam int unsigned SEEK_W  = 22;

  // default sizing
  localparam int unsigned DEF_MAX_REQUESTS = 64;
  localparam int unsigned DEF_TRACK_BITS   = 16;

  // saturation value of the running seek total
  localparam logic [SEEK_W-1:0] SEEK_MAX = '1;

  // controller states
  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_SCAN,
    S_DRAIN,
    S_COMMIT
  } ctrl_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic load;     // request beat accepted
    logic start;    // begin ordering a batch
    logic scan_rd;  // read one store entry for the nearest search
    logic commit;   // serve the nearest entry and emit a result
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic scan_last;   // scan pointer sits on the last loaded entry
    logic final_pick;  // next commit serves the last request of the batch
    logic out_free;    // result register can take a new beat
  } dp_sts_t;

endpackage

[sv/ssf_req_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssf_req_if
// Request channel: one track request per beat, with an end-of-batch mark.
// ----------------------------------------------------------------------------
interface ssf_req_if
  import ssf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [TRACK_W-1:0] request_track;
  logic               batch_end;

  modport source (output valid, output request_track, output batch_end, input ready);
  modport sink   (input valid, input request_track, input batch_end, output ready);
endinterface

[sv/ssf_res_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssf_res_if
// Result channel: one served request per beat, with the running seek total.
// ----------------------------------------------------------------------------
interface ssf_res_if
  import ssf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [TRACK_W-1:0] served_track;
  logic [SEEK_W-1:0]  total_seek;
  logic               last_of_run;
  logic               requests_dropped;

  modport source (output valid, output served_track, output total_seek,
                  output last_of_run, output requests_dropped, input ready);
  modport sink   (input valid, input served_track, input total_seek,
                  input last_of_run, input requests_dropped, output ready);
endinterface

[sv/ssf_cfg_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssf_cfg_if
// Configuration write channel for the start head register.
// ----------------------------------------------------------------------------
interface ssf_cfg_if
  import ssf_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [TRACK_W-1:0] start_head;

  modport source (output valid, output start_head, input ready);
  modport sink   (input valid, input start_head, output ready);
endinterface

[sv/ssf_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssf_ctrl
// Sequencer: loads a batch, then runs one nearest-entry scan per result.
// ----------------------------------------------------------------------------
module ssf_ctrl
  import ssf_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    req_vld_i,
  input  logic    req_end_i,
  output logic    req_rdy_o,
  input  dp_sts_t sts_i,
  output dp_cmd_t cmd_o
);

  ctrl_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d   = state_q;
    req_rdy_o = 1'b0;
    cmd_o     = '0;
    case (state_q)
      S_LOAD: begin
        req_rdy_o = 1'b1;
        if (req_vld_i) begin
          cmd_o.load = 1'b1;
          if (req_end_i) begin
            state_d = S_START;
          end
        end
      end
      S_START: begin
        cmd_o.start = 1'b1;
        state_d     = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.scan_rd = 1'b1;
        if (sts_i.scan_last) begin
          state_d = S_DRAIN;
        end
      end
      // last read beat reaches the compare stage
      S_DRAIN: begin
        state_d = S_COMMIT;
      end
      S_COMMIT: begin
        if (sts_i.out_free) begin
          cmd_o.commit = 1'b1;
          state_d      = sts_i.final_pick ? S_LOAD : S_SCAN;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
  end

endmodule

[sv/ssf_dpath.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssf_dpath
// Request store, sequential nearest-track search, seek accumulator and
// result register.
// ----------------------------------------------------------------------------
module ssf_dpath
  import ssf_pkg::*;
#(
  parameter int unsigned MAX_REQUESTS = DEF_MAX_REQUESTS,
  parameter int unsigned TRACK_BITS   = DEF_TRACK_BITS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_t            cmd_i,
  output dp_sts_t            sts_o,
  input  logic [TRACK_W-1:0] req_track_i,
  input  logic               cfg_vld_i,
  input  logic [TRACK_W-1:0] cfg_head_i,
  input  logic               res_rdy_i,
  output logic               res_vld_o,
  output logic [TRACK_W-1:0] res_track_o,
  output logic [SEEK_W-1:0]  res_seek_o,
  output logic               res_last_o,
  output logic               res_drop_o
);

  localparam int unsigned TW     = (TRACK_BITS < TRACK_W) ? TRACK_BITS : TRACK_W;
  localparam int unsigned CNT_W  = $clog2(MAX_REQUESTS + 1);
  localparam int unsigned IDX_W  = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
  localparam int unsigned WORD_W = TW + 1;

  // store word: served mark over track
  logic [WORD_W-1:0] mem_q [MAX_REQUESTS];

  logic [TW-1:0]     start_head_q;
  logic [CNT_W-1:0]  count_q;
  logic              ovf_q;
  logic [TW-1:0]     head_q;
  logic [SEEK_W-1:0] seek_q;
  logic [IDX_W-1:0]  served_q;
  logic [IDX_W-1:0]  scan_ptr_q;
  logic              rd_vld_q;
  logic [IDX_W-1:0]  rd_idx_q;
  logic [WORD_W-1:0] rd_word_q;
  logic              found_q;
  logic [IDX_W-1:0]  best_idx_q;
  logic [TW-1:0]     best_dist_q;
  logic [TW-1:0]     best_track_q;
  logic              res_vld_q;
  logic [TRACK_W-1:0] res_track_q;
  logic [SEEK_W-1:0] res_seek_q;
  logic              res_last_q;
  logic              res_drop_q;

  logic              room;
  logic [CNT_W-1:0]  cnt_m1;
  logic [IDX_W-1:0]  last_idx;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic [WORD_W-1:0] wr_word;
  logic [TW-1:0]     rd_track;
  logic              rd_served;
  logic [TW-1:0]     gap;
  logic              take;
  logic [SEEK_W:0]   seek_sum;
  logic [SEEK_W-1:0] seek_sat;

  // batch bookkeeping
  assign room     = count_q < CNT_W'(MAX_REQUESTS);
  assign cnt_m1   = count_q - CNT_W'(1);
  assign last_idx = cnt_m1[IDX_W-1:0];

  assign sts_o.scan_last  = (scan_ptr_q == last_idx);
  assign sts_o.final_pick = (served_q == last_idx);
  assign sts_o.out_free   = !res_vld_q || res_rdy_i;

  // store write port: load appends, commit sets the served mark
  assign wr_en   = (cmd_i.load && room) || cmd_i.commit;
  assign wr_addr = cmd_i.commit ? best_idx_q : count_q[IDX_W-1:0];
  assign wr_word = cmd_i.commit ? {1'b1, best_track_q} : {1'b0, req_track_i[TW-1:0]};

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_word;
    end
    if (cmd_i.scan_rd) begin
      rd_word_q <= mem_q[scan_ptr_q];
      rd_idx_q  <= scan_ptr_q;
    end
  end

  // distance compare against the best so far; ties keep the earlier entry
  assign rd_served = rd_word_q[TW];
  assign rd_track  = rd_word_q[TW-1:0];
  assign gap       = (head_q >= rd_track) ? (head_q - rd_track) : (rd_track - head_q);
  assign take      = rd_vld_q && !rd_served && (!found_q || (gap < best_dist_q));

  always_ff @(posedge clk_i) begin
    if (take) begin
      best_idx_q   <= rd_idx_q;
      best_dist_q  <= gap;
      best_track_q <= rd_track;
    end
  end

  // saturating seek accumulation
  assign seek_sum = {1'b0, seek_q} + (SEEK_W + 1)'(best_dist_q);
  assign seek_sat = seek_sum[SEEK_W] ? SEEK_MAX : seek_sum[SEEK_W-1:0];

  // control and accumulator registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_head_q <= '0;
      count_q      <= '0;
      ovf_q        <= 1'b0;
      head_q       <= '0;
      seek_q       <= '0;
      served_q     <= '0;
      scan_ptr_q   <= '0;
      rd_vld_q     <= 1'b0;
      found_q      <= 1'b0;
      res_vld_q    <= 1'b0;
    end else begin
      if (cfg_vld_i) begin
        start_head_q <= cfg_head_i[TW-1:0];
      end
      rd_vld_q <= cmd_i.scan_rd;

      if (cmd_i.load) begin
        if (room) begin
          count_q <= count_q + CNT_W'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end

      if (cmd_i.start) begin
        head_q   <= start_head_q;
        seek_q   <= '0;
        served_q <= '0;
      end

      if (cmd_i.start || cmd_i.commit) begin
        scan_ptr_q <= '0;
        found_q    <= 1'b0;
      end else begin
        if (cmd_i.scan_rd) begin
          scan_ptr_q <= scan_ptr_q + IDX_W'(1);
        end
        if (take) begin
          found_q <= 1'b1;
        end
      end

      if (cmd_i.commit) begin
        head_q   <= best_track_q;
        seek_q   <= seek_sat;
        served_q <= served_q + IDX_W'(1);
        if (sts_o.final_pick) begin
          count_q <= '0;
          ovf_q   <= 1'b0;
        end
      end

      // result beat register
      if (cmd_i.commit) begin
        res_vld_q <= 1'b1;
      end else if (res_rdy_i) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      res_track_q <= TRACK_W'(best_track_q);
      res_seek_q  <= seek_sat;
      res_last_q  <= sts_o.final_pick;
      res_drop_q  <= ovf_q;
    end
  end

  assign res_vld_o   = res_vld_q;
  assign res_track_o = res_track_q;
  assign res_seek_o  = res_seek_q;
  assign res_last_o  = res_last_q;
  assign res_drop_o  = res_drop_q;

  // scans only run over a non-empty batch
  a_scan_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.scan_rd |-> (count_q != '0))
    else $error("store scan with empty batch");

  // every commit serves an unserved entry found by the scan
  a_commit_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> found_q)
    else $error("commit without a selected entry");

  // a pending result beat is never overwritten
  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.commit |-> (!res_vld_q || res_rdy_i))
    else $error("result register overwritten");

endmodule

[sv/shortest_seek_first_scheduler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// shortest_seek_first_scheduler
// Collects a batch of track requests and returns them in shortest-seek order.
// ----------------------------------------------------------------------------
// Each request beat is stored until a beat with batch_end set closes the
// batch; requests past MAX_REQUESTS are dropped and every result of that
// batch then carries requests_dropped. Ordering starts at the configured
// start_head. For each result the nearest unserved entry is found by
// reading the request store one entry per cycle through its single read
// port, followed by a drain of the compare stage and the commit of the
// result. Requests for the next batch are not taken until the last result
// of the current batch has been committed; ties on distance go to the
// earlier request, and total_seek saturates.
module shortest_seek_first_scheduler
  import ssf_pkg::*;
#(
  parameter int unsigned MAX_REQUESTS = DEF_MAX_REQUESTS,
  parameter int unsigned TRACK_BITS   = DEF_TRACK_BITS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ssf_cfg_if.sink    cfg_i,
  ssf_req_if.sink    req_i,
  ssf_res_if.source  res_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // configuration is always taken
  assign cfg_i.ready = 1'b1;

  ssf_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_vld_i (req_i.valid),
    .req_end_i (req_i.batch_end),
    .req_rdy_o (req_i.ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  ssf_dpath #(
    .MAX_REQUESTS (MAX_REQUESTS),
    .TRACK_BITS   (TRACK_BITS)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .req_track_i (req_i.request_track),
    .cfg_vld_i   (cfg_i.valid),
    .cfg_head_i  (cfg_i.start_head),
    .res_rdy_i   (res_o.ready),
    .res_vld_o   (res_o.valid),
    .res_track_o (res_o.served_track),
    .res_seek_o  (res_o.total_seek),
    .res_last_o  (res_o.last_of_run),
    .res_drop_o  (res_o.requests_dropped)
  );

endmodule
